FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define SKT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SKT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define SKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sktab_pkg.sv
// ----------------------------------------------------------------------------
// sktab_pkg
// Types and constants of the sorted key table.
// ----------------------------------------------------------------------------
`default_nettype none

package sktab_pkg;

    localparam int KEY_IN_W = 32;
    localparam int POS_W    = 5;
    localparam int OCC_W    = 5;

    typedef enum logic [1:0] {
        KIND_FIND   = 2'd0,
        KIND_UNIQUE = 2'd1,
        KIND_BEFORE = 2'd2,
        KIND_AFTER  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LB,
        S_DUP,
        S_EXEC,
        S_SHIFT,
        S_PUT
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [KEY_IN_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             hit;
        logic             rejected_full;
        logic [OCC_W-1:0] occupancy;
    } t_rsp;

    // stored key versus request key
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

`default_nettype wire

FILE: src/sktab_mem.sv
// ----------------------------------------------------------------------------
// sktab_mem
// Key store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sktab_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: src/sktab_cmp.sv
// ----------------------------------------------------------------------------
// sktab_cmp
// Shared key comparator, unsigned or two's complement order.
// ----------------------------------------------------------------------------
`default_nettype none

module sktab_cmp #(
    parameter int WIDTH = 32
) (
    input  wire logic [WIDTH-1:0] i_stored,
    input  wire logic [WIDTH-1:0] i_key,
    input  wire logic             i_signed,
    output sktab_pkg::t_cmp       o_cmp
);

    logic [WIDTH-1:0] w_ord_stored;
    logic [WIDTH-1:0] w_ord_key;

    // flipping the sign bit maps signed order onto unsigned order
    always_comb begin
        w_ord_stored            = i_stored;
        w_ord_key               = i_key;
        w_ord_stored[WIDTH-1]   = i_stored[WIDTH-1] ^ i_signed;
        w_ord_key[WIDTH-1]      = i_key[WIDTH-1] ^ i_signed;
        o_cmp.lt                = (w_ord_stored < w_ord_key);
        o_cmp.eq                = (w_ord_stored == w_ord_key);
    end

endmodule

`default_nettype wire

FILE: src/sorted_key_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_table_unit
// Ordered key table with find and three insert kinds, one request at a time.
// ----------------------------------------------------------------------------
// A request scans the entries for the lower bound, and past equal keys for an
//   insert after them, one compare per cycle; an insert then moves the
//   (count - position) entries from the position up one slot and writes the key.
// busy stays high until o_done; a new request is taken only once busy is low.
// Reset clears the key count and the compare mode; stored keys are not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"

module sorted_key_table_unit #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire sktab_pkg::t_req i_req,
    output logic                 o_done,
    output sktab_pkg::t_rsp      o_rsp,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic            i_cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sktab_pkg::t_state      r_state, n_state;
    sktab_pkg::t_kind       r_kind, n_kind;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [AW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_pos, n_pos;
    logic                   r_eq, n_eq;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_signed;
    logic                   r_done, n_done;
    sktab_pkg::t_rsp        r_rsp, n_rsp;

    logic                   w_rd_en;
    logic [AW-1:0]          w_rd_addr;
    logic [KEY_WIDTH-1:0]   w_rd_data;
    logic                   w_wr_en;
    logic [AW-1:0]          w_wr_addr;
    logic [KEY_WIDTH-1:0]   w_wr_data;
    sktab_pkg::t_cmp        w_cmp;
    logic [63:0]            w_key_wide;
    logic [CW-1:0]          w_idx_inc;
    logic                   w_last;
    logic [CW-1:0]          w_count_dec;

    sktab_mem #(
        .DEPTH (DEPTH),
        .WIDTH (KEY_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    sktab_cmp #(
        .WIDTH (KEY_WIDTH)
    ) u_cmp (
        .i_stored (w_rd_data),
        .i_key    (r_key),
        .i_signed (r_signed),
        .o_cmp    (w_cmp)
    );

    assign w_key_wide  = {32'd0, i_req.key};
    assign w_idx_inc   = CW'(r_idx) + CW'(1);
    assign w_last      = (w_idx_inc == r_count);
    assign w_count_dec = r_count - CW'(1);

    assign busy        = (r_state != sktab_pkg::S_IDLE);
    assign o_cfg_ready = !busy;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sktab_pkg::S_IDLE;
            r_count  <= '0;
            r_signed <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_signed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_key  <= n_key;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_eq   <= n_eq;
        r_rsp  <= n_rsp;
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_key     = r_key;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_eq      = r_eq;
        n_count   = r_count;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        w_rd_en   = 1'b0;
        w_rd_addr = w_idx_inc[AW-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = w_idx_inc[AW-1:0];
        w_wr_data = w_rd_data;

        case (r_state)
            sktab_pkg::S_IDLE: begin
                if (start) begin
                    n_kind    = i_req.kind;
                    n_key     = w_key_wide[KEY_WIDTH-1:0];
                    n_idx     = '0;
                    w_rd_en   = 1'b1;
                    w_rd_addr = '0;
                    if (r_count == '0) begin
                        n_pos   = '0;
                        n_eq    = 1'b0;
                        n_state = sktab_pkg::S_EXEC;
                    end else begin
                        n_state = sktab_pkg::S_LB;
                    end
                end
            end

            // lower bound: first entry not less than the key
            sktab_pkg::S_LB: begin
                w_rd_en = 1'b1;
                if (w_cmp.lt) begin
                    if (w_last) begin
                        n_pos   = r_count;
                        n_eq    = 1'b0;
                        n_state = sktab_pkg::S_EXEC;
                    end else begin
                        n_idx = w_idx_inc[AW-1:0];
                    end
                end else begin
                    n_pos = CW'(r_idx);
                    n_eq  = w_cmp.eq;
                    if (r_kind == sktab_pkg::KIND_AFTER && w_cmp.eq) begin
                        if (w_last) begin
                            n_pos   = r_count;
                            n_state = sktab_pkg::S_EXEC;
                        end else begin
                            n_idx   = w_idx_inc[AW-1:0];
                            n_state = sktab_pkg::S_DUP;
                        end
                    end else begin
                        n_state = sktab_pkg::S_EXEC;
                    end
                end
            end

            // skip past equal keys
            sktab_pkg::S_DUP: begin
                w_rd_en = 1'b1;
                if (w_cmp.eq) begin
                    if (w_last) begin
                        n_pos   = r_count;
                        n_state = sktab_pkg::S_EXEC;
                    end else begin
                        n_idx = w_idx_inc[AW-1:0];
                    end
                end else begin
                    n_pos   = CW'(r_idx);
                    n_state = sktab_pkg::S_EXEC;
                end
            end

            sktab_pkg::S_EXEC: begin
                n_rsp.position      = sktab_pkg::POS_W'(r_pos);
                n_rsp.hit           = 1'b0;
                n_rsp.rejected_full = 1'b0;
                n_rsp.occupancy     = sktab_pkg::OCC_W'(r_count);
                if (r_kind == sktab_pkg::KIND_FIND) begin
                    n_rsp.hit = r_eq;
                    if (!r_eq) begin
                        n_rsp.position = sktab_pkg::POS_W'(r_count);
                    end
                    n_done  = 1'b1;
                    n_state = sktab_pkg::S_IDLE;
                end else if (r_count >= CW'(DEPTH)) begin
                    n_rsp.rejected_full = 1'b1;
                    n_done              = 1'b1;
                    n_state             = sktab_pkg::S_IDLE;
                end else if (r_kind == sktab_pkg::KIND_UNIQUE && r_eq) begin
                    n_done  = 1'b1;
                    n_state = sktab_pkg::S_IDLE;
                end else if (r_pos == r_count) begin
                    n_state = sktab_pkg::S_PUT;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_count_dec[AW-1:0];
                    n_idx     = w_count_dec[AW-1:0];
                    n_state   = sktab_pkg::S_SHIFT;
                end
            end

            // move entries up one slot, highest first
            sktab_pkg::S_SHIFT: begin
                w_wr_en = 1'b1;
                if (CW'(r_idx) == r_pos) begin
                    n_state = sktab_pkg::S_PUT;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx - AW'(1);
                    n_idx     = r_idx - AW'(1);
                end
            end

            sktab_pkg::S_PUT: begin
                w_wr_en             = 1'b1;
                w_wr_addr           = r_pos[AW-1:0];
                w_wr_data           = r_key;
                n_count             = r_count + CW'(1);
                n_rsp.position      = sktab_pkg::POS_W'(r_pos);
                n_rsp.hit           = 1'b1;
                n_rsp.rejected_full = 1'b0;
                n_rsp.occupancy     = sktab_pkg::OCC_W'(n_count);
                n_done              = 1'b1;
                n_state             = sktab_pkg::S_IDLE;
            end

            default: begin
                n_state = sktab_pkg::S_IDLE;
            end
        endcase
    end

    `SKT_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count over")
    `SKT_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "request not taken")
    `SKT_ASSERT_NEXT(a_put_done, i_clk, i_rst_n, r_state == sktab_pkg::S_PUT, o_done, "no done")
    `SKT_ASSERT_IMPL(a_full_nohit, i_clk, i_rst_n, o_rsp.rejected_full, !o_rsp.hit, "full hit")

endmodule

`default_nettype wire

FILE: tb/sv/sorted_key_table_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_unit_test
// Self-checking bench for the sorted key table. Drives find and insert
// requests with random spacing and predicts every response from a local
// copy of the table and the compare mode. Each response is checked field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sorted_key_table_unit_test;

    localparam int DEPTH     = 16;
    localparam int KW        = sktab_pkg::KEY_IN_W;
    localparam int SETTLE    = 2 * DEPTH + 8;
    localparam int MAX_PRINT = 40;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            start       = 1'b0;
    logic            i_cfg_valid = 1'b0;
    logic            i_cfg_data  = 1'b0;
    sktab_pkg::t_req i_req       = '0;
    logic            busy;
    logic            o_done;
    logic            o_cfg_ready;
    sktab_pkg::t_rsp o_rsp;

    // local model of the table
    logic [KW-1:0] tbl_keys [DEPTH];
    int            tbl_count;
    logic          cmp_signed;

    sktab_pkg::t_rsp pending_rsp [$];
    int              mismatch_count;
    int              next_gap;
    bit              start_held;
    bit              no_idle;

    sorted_key_table_unit #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KW)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [KW-1:0] ordered(logic [KW-1:0] k);
        return cmp_signed ? (k ^ (1 << (KW - 1))) : k;
    endfunction

    function automatic bit equal_at(int idx, logic [KW-1:0] ok);
        return idx < tbl_count && ordered(tbl_keys[idx]) == ok;
    endfunction

    function automatic sktab_pkg::t_rsp table_apply(sktab_pkg::t_req r);
        sktab_pkg::t_rsp rsp;
        logic [KW-1:0]   ok;
        int              pos;
        int              i;
        bit              hit;
        bit              full;
        bit              ins;
        ok   = ordered(r.key);
        pos  = 0;
        hit  = 1'b0;
        full = 1'b0;
        while (pos < tbl_count && ordered(tbl_keys[pos]) < ok) pos++;
        if (r.kind == sktab_pkg::KIND_FIND) begin
            hit = equal_at(pos, ok);
            if (!hit) pos = tbl_count;
        end else begin
            ins = 1'b1;
            if (r.kind == sktab_pkg::KIND_UNIQUE) begin
                if (equal_at(pos, ok)) ins = 1'b0;
            end else if (r.kind == sktab_pkg::KIND_AFTER) begin
                while (equal_at(pos, ok)) pos++;
            end
            if (tbl_count >= DEPTH) begin
                full = 1'b1;
                ins  = 1'b0;
            end
            if (ins) begin
                for (i = tbl_count; i > pos; i--) tbl_keys[i] = tbl_keys[i-1];
                tbl_keys[pos] = r.key;
                tbl_count++;
                hit = 1'b1;
            end
        end
        rsp.position      = pos[sktab_pkg::POS_W-1:0];
        rsp.hit           = hit;
        rsp.rejected_full = full;
        rsp.occupancy     = tbl_count[sktab_pkg::OCC_W-1:0];
        return rsp;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [KW-1:0] pick_key();
        logic [KW-1:0] k;
        int            r;
        r = $urandom_range(0, 9);
        if (r < 5 && tbl_count > 0) begin
            k = tbl_keys[$urandom_range(0, tbl_count - 1)];
            case ($urandom_range(0, 3))
                0: k = k - 1;
                1: k = k + 1;
                default: ;
            endcase
        end else if (r < 7) begin
            case ($urandom_range(0, 3))
                0: k = '0;
                1: k = '1;
                2: k = 1 << (KW - 1);
                default: k = ~(1 << (KW - 1));
            endcase
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    function automatic sktab_pkg::t_kind pick_kind();
        if ($urandom_range(0, 7) < 4) return sktab_pkg::KIND_FIND;
        return sktab_pkg::t_kind'($urandom_range(1, 3));
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        if (mismatch_count < MAX_PRINT)
            $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    // start is left high when the next request follows with no gap
    task automatic issue_request(sktab_pkg::t_kind kind, logic [KW-1:0] key);
        sktab_pkg::t_req r;
        r.kind = kind;
        r.key  = key;
        if (next_gap > 0) repeat (next_gap) @(posedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        pending_rsp.push_back(table_apply(r));
        next_gap = pick_gap();
        start_held = (next_gap == 0);
        if (!start_held) start <= 1'b0;
    endtask

    task automatic drain();
        if (start_held) begin
            start <= 1'b0;
            start_held = 1'b0;
        end
        do @(posedge i_clk); while (pending_rsp.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
        next_gap = 0;
    endtask

    task automatic write_mode(logic mode);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        cmp_signed = mode;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : rsp_check
        sktab_pkg::t_rsp want;
        if (i_rst_n && o_done) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response", 0, 32'(o_rsp));
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.position !== want.position)
                    report_mismatch("position", 32'(want.position), 32'(o_rsp.position));
                if (o_rsp.hit !== want.hit)
                    report_mismatch("hit", 32'(want.hit), 32'(o_rsp.hit));
                if (o_rsp.rejected_full !== want.rejected_full)
                    report_mismatch("rejected_full", 32'(want.rejected_full),
                                    32'(o_rsp.rejected_full));
                if (o_rsp.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(want.occupancy), 32'(o_rsp.occupancy));
            end
        end
    end

    task automatic test_empty_and_duplicates();
        write_mode(1'b0);
        issue_request(sktab_pkg::KIND_FIND, 32'h0000_0000);
        issue_request(sktab_pkg::KIND_UNIQUE, 32'h0000_0000);
        issue_request(sktab_pkg::KIND_UNIQUE, 32'h0000_0000);
        issue_request(sktab_pkg::KIND_BEFORE, 32'hFFFF_FFFF);
        issue_request(sktab_pkg::KIND_AFTER, 32'hFFFF_FFFF);
        issue_request(sktab_pkg::KIND_BEFORE, 32'hFFFF_FFFF);
        issue_request(sktab_pkg::KIND_FIND, 32'hFFFF_FFFF);
        issue_request(sktab_pkg::KIND_FIND, 32'h0000_0005);
        issue_request(sktab_pkg::KIND_AFTER, 32'h0000_0000);
    endtask

    // mode flip with keys already stored, table left unsorted for signed order
    task automatic test_signed_boundaries();
        write_mode(1'b1);
        issue_request(sktab_pkg::KIND_UNIQUE, 32'h8000_0000);
        issue_request(sktab_pkg::KIND_UNIQUE, 32'h7FFF_FFFF);
        issue_request(sktab_pkg::KIND_BEFORE, 32'hFFFF_FFFF);
        issue_request(sktab_pkg::KIND_FIND, 32'h8000_0000);
        issue_request(sktab_pkg::KIND_FIND, 32'h0000_0000);
    endtask

    task automatic test_fill_and_full();
        write_mode(1'b0);
        while (tbl_count < DEPTH)
            issue_request(sktab_pkg::t_kind'($urandom_range(1, 3)), $urandom);
        issue_request(sktab_pkg::KIND_UNIQUE, tbl_keys[0]);
        issue_request(sktab_pkg::KIND_BEFORE, 32'h0000_0001);
        issue_request(sktab_pkg::KIND_AFTER, 32'hFFFF_FFFF);
        issue_request(sktab_pkg::KIND_FIND, tbl_keys[3]);
    endtask

    task automatic test_random_mix();
        int ph;
        int n;
        for (ph = 0; ph < 7; ph++) begin
            if (ph == 0) write_mode(1'b1);
            else if (ph == 1) write_mode(1'b0);
            else write_mode($urandom_range(0, 1));
            no_idle = (ph == 3);
            for (n = 0; n < 100; n++) issue_request(pick_kind(), pick_key());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        tbl_count      = 0;
        cmp_signed     = 1'b0;
        mismatch_count = 0;
        next_gap       = 0;
        start_held     = 1'b0;
        no_idle        = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_duplicates();
        test_signed_boundaries();
        test_fill_and_full();
        test_random_mix();
        drain();

        if (mismatch_count == 0 && pending_rsp.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: sorted_key_table_unit.f
+incdir+src
src/sktab_pkg.sv
src/sktab_mem.sv
src/sktab_cmp.sv
src/sorted_key_table_unit.sv
tb/sv/sorted_key_table_unit_test.sv
